### src/s7p_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s7p_pkg: shared types and constants
// Mode codes, queue sizing and the result bundle passed from the engine
// to the output queue.
// ----------------------------------------------------------------------------
package s7p_pkg;

  localparam logic ModePack   = 1'b0;
  localparam logic ModeUnpack = 1'b1;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } word_t;

  typedef struct packed {
    logic [1:0] num;
    word_t      w0;
    word_t      w1;
  } res_t;

endpackage
`default_nettype wire

### src/s7p_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s7p_engine: bit buffer and pack/unpack datapath
// Holds the pending stream bits and the mode register, and turns one input
// word into zero, one or two result words in a single pass.
// ----------------------------------------------------------------------------
module s7p_engine (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_mode_i,
  input  wire logic          fire_i,
  input  wire logic [7:0]    din_i,
  input  wire logic          last_i,
  output s7p_pkg::res_t      res_o
);
  import s7p_pkg::*;

  logic       mode_q;
  logic [6:0] buf_q, buf_d;
  logic [2:0] cnt_q, cnt_d;

  logic [13:0] w14;
  logic [13:0] sh14;
  logic [2:0]  c1;
  logic [7:0]  mask8;
  logic [6:0]  rem7;
  logic [7:0]  out0;
  logic [7:0]  out1;
  logic        has0;
  logic        has1;
  logic [1:0]  num;

  always_comb begin
    w14   = '0;
    sh14  = '0;
    c1    = '0;
    out0  = '0;
    out1  = '0;
    has0  = 1'b0;
    has1  = 1'b0;
    mask8 = '0;
    rem7  = '0;
    buf_d = '0;
    cnt_d = '0;
    unique case (mode_q)
      ModePack: begin
        w14   = {buf_q, din_i[6:0]};
        has0  = (cnt_q != 3'd0);
        c1    = has0 ? (cnt_q - 3'd1) : 3'd7;
        sh14  = w14 >> c1;
        mask8 = (8'd1 << c1) - 8'd1;
        rem7  = w14[6:0] & mask8[6:0];
        has1  = last_i && (c1 != 3'd0);
        out1  = {1'b0, rem7} << (4'd8 - {1'b0, c1});
        out0  = has0 ? sh14[7:0] : out1;
        buf_d = rem7;
        cnt_d = c1;
      end
      ModeUnpack: begin
        w14   = {buf_q[5:0], din_i};
        c1    = cnt_q + 3'd1;
        sh14  = w14 >> c1;
        out0  = {1'b0, sh14[6:0]};
        out1  = {1'b0, w14[6:0]};
        has0  = 1'b1;
        has1  = (c1 == 3'd7);
        mask8 = (8'd1 << c1) - 8'd1;
        rem7  = has1 ? 7'd0 : (w14[6:0] & mask8[6:0]);
        buf_d = rem7;
        cnt_d = has1 ? 3'd0 : c1;
      end
      default: ;
    endcase
    if (last_i) begin
      buf_d = '0;
      cnt_d = '0;
    end
  end

  // pack with no full byte yet still yields the flush word in slot 0
  assign num = (mode_q == ModePack) ?
               ((has0 && has1) ? 2'd2 : ((has0 || has1) ? 2'd1 : 2'd0)) :
               (has1 ? 2'd2 : 2'd1);

  always_comb begin
    res_o.num     = fire_i ? num : 2'd0;
    res_o.w0.data = out0;
    res_o.w0.last = last_i && (num == 2'd1);
    res_o.w1.data = out1;
    res_o.w1.last = last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModePack;
      buf_q  <= '0;
      cnt_q  <= '0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_mode_i;
      buf_q  <= '0;
      cnt_q  <= '0;
    end else if (fire_i) begin
      buf_q  <= buf_d;
      cnt_q  <= cnt_d;
    end
  end

  a_unpack_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ModeUnpack) |-> (cnt_q <= 3'd6))
    else $error("unpack bit count out of range");

  a_last_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && last_i) |=> (cnt_q == 3'd0) && (buf_q == 7'd0))
    else $error("stream state not cleared after last word");

  a_last_yields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && last_i) |-> (res_o.num != 2'd0))
    else $error("last word produced no result");

endmodule
`default_nettype wire

### src/s7p_out_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s7p_out_queue: result word queue
// Small queue that takes up to two words per cycle and drives the master
// stream one word per cycle while m_ready_i is high.
// ----------------------------------------------------------------------------
module s7p_out_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  s7p_pkg::res_t      res_i,
  output logic               room_o,
  output logic               m_valid_o,
  input  wire logic          m_ready_i,
  output s7p_pkg::word_t     m_word_o
);
  import s7p_pkg::*;

  word_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             pop;
  logic [QPtrW-1:0] wr_nx;

  assign room_o    = (cnt_q <= QCntW'(QDepth - 2));
  assign m_valid_o = (cnt_q != '0);
  assign pop       = m_valid_o && m_ready_i;
  assign wr_nx     = wr_q + QPtrW'(1);
  assign m_word_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (res_i.num != 2'd0) begin
      mem_q[wr_q] <= res_i.w0;
    end
    if (res_i.num == 2'd2) begin
      mem_q[wr_nx] <= res_i.w1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QPtrW'(res_i.num);
      rd_q  <= rd_q + QPtrW'(pop);
      cnt_q <= cnt_q + QCntW'(res_i.num) - QCntW'(pop);
    end
  end

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("queue overflow");

  a_push_fits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_i.num != 2'd0) |-> (cnt_q <= QCntW'(QDepth) - QCntW'(res_i.num)))
    else $error("push without room");

  a_pop_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && res_i.num == 2'd0) |=> (cnt_q == $past(cnt_q) - QCntW'(1)))
    else $error("queue count mismatch on pop");

endmodule
`default_nettype wire

### src/seven_bit_text_packer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seven_bit_text_packer_core: seven-bit text packer / unpacker
// Packs 8-bit text bytes into a dense MSB-first 7-bit stream, or unpacks it.
//
// Usage:
//   s_axis: one text byte per word, tlast marks the final byte of a file.
//   m_axis: output bytes, tlast on the final byte of the file.
//   cfg:    one-bit mode write (0 pack, 1 unpack); always ready. Write only
//           while idle; a write also clears the pending bit buffer.
// Path: input register, single-pass engine, then the result queue.
// Throughput: one input word per cycle while the queue has room, set by the
//   single-pass datapath between the input register and the result queue.
//   Words yielding two results leave as two output words; the 4-entry queue
//   absorbs this and tready drops only when fewer than two entries are free.
// Reset: mode returns to pack, buffer and queue empty.
// Stall: while m_axis_tready is low, results wait in the queue; when fewer
//   than two entries are free, the input register holds and tready falls.
// ----------------------------------------------------------------------------
module seven_bit_text_packer_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  wire logic       s_axis_tlast,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic            m_axis_tlast,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [0:0] cfg_data_i      // [0] mode
);
  import s7p_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_data_q;
  logic       in_last_q;
  logic       room;
  logic       advance;
  logic       cfg_we;
  res_t       res;
  word_t      m_word;

  assign cfg_ready_o   = 1'b1;
  assign cfg_we        = cfg_valid_i && cfg_ready_o;
  assign advance       = in_valid_q && room;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  s7p_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_mode_i (cfg_data_i[0]),
    .fire_i     (advance),
    .din_i      (in_data_q),
    .last_i     (in_last_q),
    .res_o      (res)
  );

  s7p_out_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .res_i     (res),
    .room_o    (room),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_word_o  (m_word)
  );

  assign m_axis_tdata = m_word.data;
  assign m_axis_tlast = m_word.last;

endmodule
`default_nettype wire

### tb/septet_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// septet_stream_checker: output predictor and scoreboard
// Watches the mode write channel and both stream sides of the seven-bit
// text packer. Each accepted input word is run through a local pack/unpack
// model. The model's output bytes are queued in order, and each accepted
// output word is compared against the oldest one.
// ----------------------------------------------------------------------------
module septet_stream_checker (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_tvalid_i,
  input  wire logic       s_tready_i,
  input  wire logic [7:0] s_tdata_i,
  input  wire logic       s_tlast_i,
  input  wire logic       m_tvalid_i,
  input  wire logic       m_tready_i,
  input  wire logic [7:0] m_tdata_i,
  input  wire logic       m_tlast_i,
  input  wire logic       cfg_valid_i,
  input  wire logic       cfg_ready_i,
  input  wire logic [0:0] cfg_data_i,
  output int              fail_count_o,
  output int              pending_o
);
  import s7p_pkg::*;

  logic        mode_q;
  logic [14:0] pend_bits;
  logic [3:0]  pend_count;
  word_t       expected_bytes[$];
  word_t       want;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // Advance the bit buffer by one input word and queue the bytes it releases.
  task automatic predict_word(input logic [7:0] b, input logic lst);
    logic [15:0] acc;
    int          cnt;
    int          n;
    word_t       res[2];
    acc = {1'b0, pend_bits};
    cnt = pend_count;
    n   = 0;
    if (mode_q == ModePack) begin
      acc = ((acc << 7) | {9'b0, b[6:0]}) & 16'h7FFF;
      cnt += 7;
      if (cnt >= 8) begin
        cnt -= 8;
        res[n].data = 8'(acc >> cnt);
        res[n].last = 1'b0;
        n++;
        acc &= (16'd1 << cnt) - 16'd1;
      end
      // flush: pending bits left-aligned, zero padded
      if (lst && cnt > 0) begin
        res[n].data = 8'(acc << (8 - cnt));
        res[n].last = 1'b0;
        n++;
      end
    end else begin
      acc = ((acc << 8) | {8'b0, b}) & 16'h7FFF;
      cnt += 8;
      while (cnt >= 7 && n < 2) begin
        cnt -= 7;
        res[n].data = {1'b0, 7'(acc >> cnt)};
        res[n].last = 1'b0;
        n++;
        acc &= (16'd1 << cnt) - 16'd1;
      end
    end
    if (lst) begin
      if (n > 0) res[n-1].last = 1'b1;
      acc = '0;
      cnt = 0;
    end
    for (int i = 0; i < n; i++) expected_bytes.push_back(res[i]);
    pend_bits  = acc[14:0];
    pend_count = 4'(cnt);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     = ModePack;
      pend_bits  = '0;
      pend_count = '0;
      expected_bytes.delete();
      pending_o <= 0;
    end else begin
      // output first: a word leaving now never stems from a word entering now
      if (m_tvalid_i && m_tready_i) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected output word: out_byte %02h out_last %0b", m_tdata_i, m_tlast_i);
          fail_count_o++;
        end else begin
          want = expected_bytes.pop_front();
          if (m_tdata_i !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, m_tdata_i);
            fail_count_o++;
          end
          if (m_tlast_i !== want.last) begin
            $error("out_last: expected %0b, got %0b", want.last, m_tlast_i);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        mode_q     = cfg_data_i[0];
        pend_bits  = '0;
        pend_count = '0;
      end
      if (s_tvalid_i && s_tready_i) predict_word(s_tdata_i, s_tlast_i);
      pending_o <= expected_bytes.size();
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: seven-bit text packer stimulus and verdict
// Runs directed pack and unpack files, then random files in both modes with
// mode changes between and inside files, under three idle patterns. Includes
// one long output stall. Checking is done by the scoreboard instance.
// ----------------------------------------------------------------------------
module testbench;
  import s7p_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int HoldCycles    = 300;
  localparam int DrainCycles   = 8;
  localparam int ItemsPerPhase = 360;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic [7:0] s_axis_tdata  = '0;
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tready = 1'b0;
  logic       cfg_valid_i   = 1'b0;
  logic [0:0] cfg_data_i    = '0;
  wire logic       s_axis_tready;
  wire logic       m_axis_tvalid;
  wire logic [7:0] m_axis_tdata;
  wire logic       m_axis_tlast;
  wire logic       cfg_ready_o;

  int   fail_count;
  int   pending;
  int   idle_phase  = 0;
  int   items_sent  = 0;
  int   quiet_count = 0;
  logic hold_go     = 1'b0;
  logic hold_done   = 1'b0;
  int   hold_cnt    = 0;

  seven_bit_text_packer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  septet_stream_checker scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tlast_i    (s_axis_tlast),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tlast_i    (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int tx_idle_pct();
    return (idle_phase == 0) ? 37 : (idle_phase == 1) ? 67 : 0;
  endfunction

  function automatic int rx_idle_pct();
    return (idle_phase == 0) ? 67 : (idle_phase == 1) ? 37 : 0;
  endfunction

  // receiver: random backpressure, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_go && !hold_done) begin
      m_axis_tready <= 1'b0;
      if (hold_cnt == HoldCycles) hold_done <= 1'b1;
      else hold_cnt <= hold_cnt + 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct());
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_count <= 0;
    end else if (quiet_count >= WatchdogLimit) begin
      $display("seven_bit_text_packer_core test failed");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  task automatic send_word(input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < tx_idle_pct()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  // stop sending and wait until every predicted byte has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int len;
    int phase_end;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pack: eight bytes to seven, bit 7 ignored
    send_word(8'h00, 1'b0); send_word(8'hFF, 1'b0); send_word(8'h7F, 1'b0);
    send_word(8'h80, 1'b0); send_word(8'h41, 1'b0); send_word(8'h55, 1'b0);
    send_word(8'hAA, 1'b0); send_word(8'h01, 1'b1);
    // pack flush of short files
    send_word(8'h7F, 1'b1);
    send_word(8'h80, 1'b0); send_word(8'h3F, 1'b1);

    // unpack: seven bytes to eight
    write_mode(ModeUnpack);
    send_word(8'hFF, 1'b0); send_word(8'h00, 1'b0); send_word(8'h80, 1'b0);
    send_word(8'h7F, 1'b0); send_word(8'hAA, 1'b0); send_word(8'h55, 1'b0);
    send_word(8'h01, 1'b1);
    // leftover bit dropped on last
    send_word(8'hFE, 1'b1);
    // mode write mid-file clears the buffer
    send_word(8'h12, 1'b0); send_word(8'h34, 1'b0); send_word(8'h56, 1'b0);
    write_mode(ModeUnpack);
    send_word(8'h78, 1'b1);

    for (int ph = 0; ph < 3; ph++) begin
      idle_phase <= ph;
      if (ph == 0) begin
        hold_go <= 1'b1;
        for (int i = 0; i < 40; i++) send_word(8'($urandom_range(255)), i == 39);
        write_mode(ModePack);
      end
      phase_end = items_sent + ItemsPerPhase;
      while (items_sent < phase_end) begin
        if ($urandom_range(3) == 0) write_mode(1'($urandom_range(1)));
        len = ($urandom_range(9) == 0) ? $urandom_range(60, 17) : $urandom_range(16, 1);
        for (int i = 0; i < len; i++) begin
          if (i > 0 && $urandom_range(49) == 0) write_mode(1'($urandom_range(1)));
          send_word(8'($urandom_range(255)), i == len - 1);
        end
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("seven_bit_text_packer_core test passed");
    end else begin
      $display("seven_bit_text_packer_core test failed");
    end
    $finish;
  end

endmodule
